/* hw/rtl/rrog_pkg.sv */
// Shared types, constants and helpers of the rounded rectangle outline generator.
`default_nettype none
package rrog_pkg;

	localparam int COORD_BITS = 16;
	localparam int PPC_BITS   = 5;
	localparam logic [PPC_BITS-1:0] MAX_POINTS  = 5'd16;
	localparam logic [PPC_BITS-1:0] PPC_RESET   = 5'd8;

	typedef struct packed {
		logic [COORD_BITS-1:0] width;
		logic [COORD_BITS-1:0] height;
		logic [COORD_BITS-1:0] radius;
		logic [3:0]            corner_mask;
	} shape_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] vertex_x;
		logic [COORD_BITS-1:0] vertex_y;
		logic                  last_vertex;
	} vertex_t;

	// one shape as handed from the front to the back: r = quo * n + rem
	typedef struct packed {
		shape_t                shape;
		logic [PPC_BITS-1:0]   n;
		logic [COORD_BITS-1:0] quo;
		logic [PPC_BITS-2:0]   rem;
	} job_t;

	typedef enum logic [1:0] {
		CORNER_TR,
		CORNER_BR,
		CORNER_BL,
		CORNER_TL
	} corner_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_RSQ,
		B_CORNER,
		B_STEP,
		B_SQUARE,
		B_DIFF,
		B_SQRT,
		B_EMIT
	} back_state_t;

	function automatic logic corner_rounded(input logic [3:0] mask, input corner_t c);
		logic r;
		case (c)
			CORNER_TR: r = mask[1];
			CORNER_BR: r = mask[2];
			CORNER_BL: r = mask[3];
			CORNER_TL: r = mask[0];
			default:   r = 1'b0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/rrog_front.sv */
// Front end: takes a shape request, clamps the point count and divides radius by it.
`default_nettype none
module rrog_front
	import rrog_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shape_valid,
	output logic                shape_stall,
	input  shape_t              shape,
	input  logic [PPC_BITS-1:0] ppc,
	input  logic                full,
	output logic                push,
	output job_t                job
);

	front_state_t          state_q, state_d;
	shape_t                shape_q;
	logic [PPC_BITS-1:0]   n_q;
	logic [COORD_BITS-1:0] quo_q;
	logic [PPC_BITS-2:0]   rem_q;
	logic [3:0]            it_q;
	logic [PPC_BITS-1:0]   n_clamped;
	logic [PPC_BITS-1:0]   rem_t;
	logic                  fits;
	logic                  accept;

	always_comb begin
		if (ppc == '0) begin
			n_clamped = PPC_BITS'(1);
		end else if (ppc > MAX_POINTS) begin
			n_clamped = MAX_POINTS;
		end else begin
			n_clamped = ppc;
		end
	end

	assign shape_stall = (state_q != F_IDLE);
	assign accept      = shape_valid && !shape_stall;
	assign push        = (state_q == F_PUSH) && !full;

	// restoring division, one quotient bit per cycle
	assign rem_t = {rem_q, quo_q[COORD_BITS-1]};
	assign fits  = (rem_t >= n_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) state_d = F_DIV;
			end
			F_DIV: begin
				if (it_q == 4'(COORD_BITS - 1)) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			it_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == F_DIV) it_q <= it_q + 4'd1;
			else it_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shape_q <= shape;
			n_q     <= n_clamped;
			quo_q   <= shape.radius;
			rem_q   <= '0;
		end else if (state_q == F_DIV) begin
			quo_q <= {quo_q[COORD_BITS-2:0], fits};
			rem_q <= fits ? (PPC_BITS-1)'(rem_t - n_q) : rem_t[PPC_BITS-2:0];
		end
	end

	assign job.shape = shape_q;
	assign job.n     = n_q;
	assign job.quo   = quo_q;
	assign job.rem   = rem_q;

	a_rem_below_n: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_PUSH) |-> ({1'b0, rem_q} < n_q))
		else $error("front: division remainder not below point count");

	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != F_IDLE) |-> (n_q != '0 && n_q <= MAX_POINTS))
		else $error("front: point count out of range");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == F_PUSH) |-> $past(it_q) == 4'(COORD_BITS - 1))
		else $error("front: division ended early");

endmodule
`default_nettype wire

/* hw/rtl/rrog_queue.sv */
// Short job queue between the front end and the vertex back end.
`default_nettype none
module rrog_queue
	import rrog_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output job_t rd_job,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue: push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue: pop while empty");

endmodule
`default_nettype wire

/* hw/rtl/rrog_back.sv */
// Back end: walks corners and arc steps, takes the square root, drives the vertex register.
`default_nettype none
module rrog_back
	import rrog_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    empty,
	input  job_t    rd_job,
	output logic    pop,
	output logic    vertex_valid,
	input  logic    vertex_stall,
	output vertex_t vertex
);

	back_state_t             state_q, state_d;
	job_t                    job_q;
	corner_t                 corner_q;
	logic                    arc_q;
	logic [PPC_BITS-1:0]     k_q;
	logic [COORD_BITS-1:0]   off_q;
	logic [PPC_BITS-1:0]     racc_q;
	logic [2*COORD_BITS-1:0] rr_q;
	logic [2*COORD_BITS-1:0] sq_q;
	logic [2*COORD_BITS-1:0] rad_q;
	logic [COORD_BITS+1:0]   srem_q;
	logic [COORD_BITS-1:0]   root_q;
	logic [3:0]              it_q;
	vertex_t                 vertex_q;
	logic                    vertex_valid_q;

	logic                    out_free;
	logic                    load;
	logic                    rounded;
	logic                    last_pt;
	logic [PPC_BITS-1:0]     racc_t;
	logic                    carry;
	logic [COORD_BITS+3:0]   srem_t;
	logic [COORD_BITS+3:0]   trial;
	logic                    take;
	logic [COORD_BITS-1:0]   w, h, r, x_d, y_d;

	assign w = job_q.shape.width;
	assign h = job_q.shape.height;
	assign r = job_q.shape.radius;

	assign pop      = (state_q == B_IDLE) && !empty;
	assign out_free = !vertex_valid_q || !vertex_stall;
	assign load     = (state_q == B_EMIT) && out_free;
	assign rounded  = corner_rounded(job_q.shape.corner_mask, corner_q);
	assign last_pt  = !arc_q || (k_q == job_q.n);

	// off = floor(k*r/n) kept as k*quo plus a running remainder
	assign racc_t = racc_q + PPC_BITS'(job_q.rem);
	assign carry  = (racc_t >= job_q.n);

	// square root, two radicand bits per cycle
	assign srem_t = {srem_q, rad_q[2*COORD_BITS-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign take   = (srem_t >= trial);

	always_comb begin
		x_d = '0;
		y_d = '0;
		if (arc_q) begin
			case (corner_q)
				CORNER_TR: begin x_d = off_q + w - r;  y_d = r - root_q;     end
				CORNER_BR: begin x_d = w + root_q - r; y_d = h - r + off_q;  end
				CORNER_BL: begin x_d = r - off_q;      y_d = h - r + root_q; end
				default:   begin x_d = r - root_q;     y_d = r - off_q;      end
			endcase
		end else begin
			case (corner_q)
				CORNER_TR: begin x_d = w;  y_d = '0; end
				CORNER_BR: begin x_d = w;  y_d = h;  end
				CORNER_BL: begin x_d = '0; y_d = h;  end
				default:   begin x_d = '0; y_d = '0; end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:   if (!empty) state_d = B_RSQ;
			B_RSQ:    state_d = B_CORNER;
			B_CORNER: state_d = rounded ? B_STEP : B_EMIT;
			B_STEP:   state_d = B_SQUARE;
			B_SQUARE: state_d = B_DIFF;
			B_DIFF:   state_d = B_SQRT;
			B_SQRT:   if (it_q == 4'(COORD_BITS - 1)) state_d = B_EMIT;
			B_EMIT: begin
				if (out_free) begin
					if (!last_pt) state_d = B_STEP;
					else if (corner_q == CORNER_TL) state_d = B_IDLE;
					else state_d = B_CORNER;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= B_IDLE;
			corner_q       <= CORNER_TR;
			arc_q          <= 1'b0;
			k_q            <= '0;
			racc_q         <= '0;
			it_q           <= '0;
			vertex_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_SQRT) it_q <= it_q + 4'd1;
			else it_q <= '0;
			if (load) vertex_valid_q <= 1'b1;
			else if (!vertex_stall) vertex_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					corner_q <= CORNER_TR;
					k_q      <= '0;
					racc_q   <= '0;
				end
				B_CORNER: arc_q <= rounded;
				B_STEP: begin
					k_q    <= k_q + 1'b1;
					racc_q <= carry ? racc_t - job_q.n : racc_t;
				end
				B_EMIT: begin
					if (out_free && last_pt && corner_q != CORNER_TL) begin
						corner_q <= corner_t'(corner_q + 2'd1);
						k_q      <= '0;
						racc_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= rd_job;
		if (load) begin
			vertex_q.vertex_x    <= x_d;
			vertex_q.vertex_y    <= y_d;
			vertex_q.last_vertex <= last_pt && (corner_q == CORNER_TL);
		end
		case (state_q)
			B_RSQ:    rr_q <= r * r;
			B_CORNER: off_q <= '0;
			B_STEP:   off_q <= off_q + job_q.quo + COORD_BITS'(carry);
			B_SQUARE: sq_q <= off_q * off_q;
			B_DIFF: begin
				rad_q  <= rr_q - sq_q;
				srem_q <= '0;
				root_q <= '0;
			end
			B_SQRT: begin
				rad_q  <= {rad_q[2*COORD_BITS-3:0], 2'b00};
				srem_q <= take ? (COORD_BITS+2)'(srem_t - trial) : srem_t[COORD_BITS+1:0];
				root_q <= {root_q[COORD_BITS-2:0], take};
			end
			default: ;
		endcase
	end

	assign vertex_valid = vertex_valid_q;
	assign vertex       = vertex_q;

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_EMIT && arc_q) |-> (k_q != '0 && k_q <= job_q.n))
		else $error("back: arc step outside 1..n");

	a_racc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SQUARE) |-> (racc_q < job_q.n))
		else $error("back: running remainder not below n");

	a_off_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_SQUARE) |-> (off_q <= r))
		else $error("back: arc offset beyond radius");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(vertex_valid_q && vertex_stall) |=> $stable(vertex_q))
		else $error("back: held vertex overwritten");

endmodule
`default_nettype wire

/* hw/rtl/rounded_rect_outline_generator_unit.sv */
// Top level of the rounded rectangle outline generator.
// Usage:
//   shape channel (shape_valid/shape_stall/shape): one request per rectangle with
//   width, height, radius (unsigned Q12.4) and the mask of rounded corners.
//   vertex channel (vertex_valid/vertex_stall/vertex): outline vertices clockwise,
//   corners top-right, bottom-right, bottom-left, top-left; last_vertex marks the end.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): points per rounded corner, reset 8;
//   0 acts as 1, values above 16 act as 16. Write it only while the block is idle.
// Sequencing:
//   The front end handles one request at a time (accept, 16-step divide, hand-off) and
//   the queue can hold QUEUE_DEPTH more requests ahead of the back end.
//   The back end starts a shape in B_IDLE and B_RSQ, starts each corner in B_CORNER,
//   builds each arc vertex in B_STEP, B_SQUARE, B_DIFF, the 16-step square root in
//   B_SQRT and B_EMIT, and builds each square corner vertex in B_EMIT alone.
// A stalled vertex is held in the output register; the back end waits on it and the
// front end keeps filling the queue. Reset empties the queue and drops pending work.
`default_nettype none
module rounded_rect_outline_generator_unit
	import rrog_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shape_valid,
	output logic                shape_stall,
	input  shape_t              shape,
	output logic                vertex_valid,
	input  logic                vertex_stall,
	output vertex_t             vertex,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [PPC_BITS-1:0] cfg_data
);

	logic [PPC_BITS-1:0] ppc_q;
	logic                push, pop, full, empty;
	job_t                wr_job, rd_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppc_q <= PPC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ppc_q <= cfg_data;
		end
	end

	rrog_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.shape_valid (shape_valid),
		.shape_stall (shape_stall),
		.shape       (shape),
		.ppc         (ppc_q),
		.full        (full),
		.push        (push),
		.job         (wr_job)
	);

	rrog_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (wr_job),
		.full   (full),
		.pop    (pop),
		.rd_job (rd_job),
		.empty  (empty)
	);

	rrog_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.rd_job       (rd_job),
		.pop          (pop),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex)
	);

endmodule
`default_nettype wire

/* verif/tb_rounded_rect_outline_generator_unit.sv */
// Testbench of the rounded rectangle outline generator: shape requests in, predicted vertices checked.
module tb_rounded_rect_outline_generator_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rrog_pkg::*;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                shape_valid  = 1'b0;
	logic                shape_stall;
	shape_t              shape_req    = '0;
	logic                vertex_valid;
	logic                vertex_stall = 1'b0;
	vertex_t             vertex_out;
	logic                cfg_valid    = 1'b0;
	logic                cfg_ready;
	logic [PPC_BITS-1:0] cfg_data     = PPC_RESET;

	// predictor state: points per corner as last written
	logic [PPC_BITS-1:0] points_setting = PPC_RESET;
	vertex_t             pending_vertices[$];
	vertex_t             want;

	int tx_gap_max   = 5;
	int rx_stall_max = 5;
	int stall_run    = 0;
	int shapes_sent  = 0;
	int vertices_seen = 0;
	int settings_used = 1;
	int mismatches   = 0;

	rounded_rect_outline_generator_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.shape_valid  (shape_valid),
		.shape_stall  (shape_stall),
		.shape        (shape_req),
		.vertex_valid (vertex_valid),
		.vertex_stall (vertex_stall),
		.vertex       (vertex_out),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [15:0] floor_sqrt(input logic [31:0] v);
		logic [15:0] res;
		logic [31:0] trial;
		res = '0;
		for (int b = 15; b >= 0; b--) begin
			trial = {16'd0, res | (16'd1 << b)};
			if (trial * trial <= v)
				res = res | (16'd1 << b);
		end
		return res;
	endfunction

	// Expected outline of one shape, appended to pending_vertices.
	function automatic void build_outline(input shape_t s);
		logic [PPC_BITS-1:0] n;
		logic [31:0]         rsq;
		logic [31:0]         off;
		logic [15:0]         root;
		logic [15:0]         x;
		logic [15:0]         y;
		corner_t             c;
		logic                round;
		int                  steps;
		vertex_t             held;
		bit                  have;
		n = (points_setting == 0) ? 5'd1 :
			(points_setting > MAX_POINTS) ? MAX_POINTS : points_setting;
		rsq = s.radius * s.radius;
		have = 1'b0;
		held = '0;
		for (int i = 0; i < 4; i++) begin
			c = corner_t'(i);
			case (c)
				CORNER_TR: round = s.corner_mask[1];
				CORNER_BR: round = s.corner_mask[2];
				CORNER_BL: round = s.corner_mask[3];
				default:   round = s.corner_mask[0];
			endcase
			steps = round ? int'(n) : 1;
			for (int k = 1; k <= steps; k++) begin
				if (round) begin
					off = (k * s.radius) / n;
					root = floor_sqrt(rsq - off * off);
					case (c)
						CORNER_TR: begin
							x = off + s.width - s.radius;
							y = s.radius - root;
						end
						CORNER_BR: begin
							x = s.width + root - s.radius;
							y = s.height - s.radius + off;
						end
						CORNER_BL: begin
							x = s.radius - off;
							y = s.height - s.radius + root;
						end
						default: begin
							x = s.radius - root;
							y = s.radius - off;
						end
					endcase
				end else begin
					case (c)
						CORNER_TR: begin x = s.width; y = '0;       end
						CORNER_BR: begin x = s.width; y = s.height; end
						CORNER_BL: begin x = '0;      y = s.height; end
						default:   begin x = '0;      y = '0;       end
					endcase
				end
				if (have)
					pending_vertices.push_back(held);
				held.vertex_x = x;
				held.vertex_y = y;
				held.last_vertex = 1'b0;
				have = 1'b1;
			end
		end
		held.last_vertex = 1'b1;
		pending_vertices.push_back(held);
	endfunction

	// vertex checker and receiver stall generator
	always @(posedge clk) begin
		if (arst_n) begin
			if (vertex_valid && !vertex_stall) begin
				vertices_seen++;
				if (pending_vertices.size() == 0) begin
					$error("unexpected vertex x=%0h y=%0h", vertex_out.vertex_x,
						vertex_out.vertex_y);
					mismatches++;
				end else begin
					want = pending_vertices.pop_front();
					if (vertex_out.vertex_x !== want.vertex_x) begin
						$error("vertex_x expected %0h actual %0h", want.vertex_x,
							vertex_out.vertex_x);
						mismatches++;
					end
					if (vertex_out.vertex_y !== want.vertex_y) begin
						$error("vertex_y expected %0h actual %0h", want.vertex_y,
							vertex_out.vertex_y);
						mismatches++;
					end
					if (vertex_out.last_vertex !== want.last_vertex) begin
						$error("last_vertex expected %0b actual %0b", want.last_vertex,
							vertex_out.last_vertex);
						mismatches++;
					end
				end
				stall_run = $urandom_range(0, rx_stall_max);
			end else if (stall_run != 0) begin
				stall_run--;
			end
			vertex_stall <= (stall_run != 0);
		end
	end

	// One shape request; returns once shape_stall is seen low after an edge with the request driven.
	task automatic send_shape(input shape_t s);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap != 0) begin
			shape_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		shape_valid <= 1'b1;
		shape_req <= s;
		@(posedge clk);
		while (shape_stall) @(posedge clk);
		build_outline(s);
		shapes_sent++;
	endtask

	task automatic send_fields(input logic [15:0] w, input logic [15:0] h,
		input logic [15:0] r, input logic [3:0] m);
		shape_t s;
		s.width = w;
		s.height = h;
		s.radius = r;
		s.corner_mask = m;
		send_shape(s);
	endtask

	task automatic wait_idle();
		shape_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_points(input logic [PPC_BITS-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		points_setting = v;
		settings_used++;
	endtask

	// every corner mask at the reset point count
	task automatic test_mask_sweep();
		for (int m = 0; m < 16; m++)
			send_fields(16'h0640, 16'h0320, 16'h00a0, 4'(m));
	endtask

	task automatic test_edge_geometry();
		send_fields(16'h0000, 16'h0000, 16'h0000, 4'hf);
		send_fields(16'hffff, 16'hffff, 16'hffff, 4'hf);
		send_fields(16'hffff, 16'hffff, 16'h0000, 4'h5);
		send_fields(16'h0010, 16'h0010, 16'h0100, 4'hf);
		send_fields(16'h0200, 16'h0080, 16'h0040, 4'ha);
		send_fields(16'h0000, 16'h0000, 16'hffff, 4'hf);
	endtask

	// zero, minimum, maximum and saturating point counts
	task automatic test_points_extremes();
		logic [PPC_BITS-1:0] vals[5];
		vals = '{5'd0, 5'd1, 5'd16, 5'd17, 5'd31};
		foreach (vals[i]) begin
			wait_idle();
			write_points(vals[i]);
			send_fields(16'h0c80, 16'h0960, 16'h0320, 4'hf);
		end
	endtask

	task automatic test_random_shapes();
		shape_t s;
		int     lim;
		for (int phase = 0; phase < 4; phase++) begin
			wait_idle();
			write_points(5'($urandom_range(0, 31)));
			tx_gap_max   = (phase == 1 || phase == 3) ? 0 : 5;
			rx_stall_max = (phase == 1 || phase == 2) ? 0 : 5;
			for (int i = 0; i < 48; i++) begin
				s.width = 16'($urandom_range(0, 65535));
				s.height = 16'($urandom_range(0, 65535));
				s.corner_mask = 4'($urandom_range(0, 15));
				if ($urandom_range(0, 3) != 0) begin
					lim = ((s.width < s.height) ? s.width : s.height) / 2;
					s.radius = 16'($urandom_range(0, lim));
				end else begin
					s.radius = 16'($urandom_range(0, 65535));
				end
				send_shape(s);
			end
		end
		tx_gap_max = 5;
		rx_stall_max = 5;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_mask_sweep();
		test_edge_geometry();
		test_points_extremes();
		test_random_shapes();
		wait_idle();
		$display("Drew %0d shapes under %0d point-count settings, %0d vertices compared.",
			shapes_sent, settings_used, vertices_seen);
		$display("Covered all corner masks, zero and oversized radii, point counts 0..31.");
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
